@@ rtl/core/rc_pkg.sv @@
// rc_pkg: shared types and constants for the radix converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rc_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_LOAD,
        ST_EMIT
    } rc_state_t;

    // Configuration register indexes
    localparam logic REG_SRC_BASE = 1'b0;
    localparam logic REG_DST_BASE = 1'b1;

    localparam int BASE_WIDTH    = 6;
    localparam int CHAR_WIDTH    = 8;
    localparam int DIGIT_WIDTH   = 9;  // signed digit value, -55..200
    localparam int STACK_DEPTH   = 32;
    localparam int STACK_AW      = 5;
    localparam int COUNT_WIDTH   = 6;

    localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_WIDTH-1:0] BASE_MAX   = 6'd36;

    localparam logic [CHAR_WIDTH-1:0] LOWER_TO_UPPER = 8'd32;
    localparam logic [CHAR_WIDTH-1:0] LETTER_OFFSET  = 8'd10;
    localparam logic [CHAR_WIDTH-1:0] DIGIT_LIMIT    = 8'd10;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO      = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE      = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z   = 8'h7A;

    // Character to signed digit value (no range check against the base)
    function automatic logic [DIGIT_WIDTH-1:0] char_to_digit(input logic [CHAR_WIDTH-1:0] ch);
        logic [CHAR_WIDTH-1:0] up;
        up = ch;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
            up = ch - LOWER_TO_UPPER;
        if (up >= CHAR_ZERO && up <= CHAR_NINE)
            char_to_digit = {1'b0, up - CHAR_ZERO};
        else
            char_to_digit = {1'b0, up} - {1'b0, CHAR_UPPER_A} + {1'b0, LETTER_OFFSET};
    endfunction

    // Digit value 0..35 to ASCII
    function automatic logic [6:0] digit_to_ascii(input logic [BASE_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] wide;
        if ({2'b00, d} >= DIGIT_LIMIT)
            wide = {2'b00, d} - DIGIT_LIMIT + CHAR_UPPER_A;
        else
            wide = {2'b00, d} + CHAR_ZERO;
        digit_to_ascii = wide[6:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/radix_converter.sv @@
// radix_converter: ASCII numeral base conversion, bit-serial multiply and divide.
// Depends on rc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each character word goes through accept, 6 shift-add steps over the bits
// of src_base and one digit add. On the last character, each output digit
// comes from restoring division of the value (one quotient bit per cycle),
// and the digits are read back from the digit stack via a load and an emit
// state per word. New characters are accepted only in idle. Reset (rst_n,
// async) clears the control state and accumulator and sets both bases to 10.

module radix_converter #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_char
    input  wire logic       s_tlast,   // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] out_char, [7] zero fill
    output logic            m_tlast,   // out_last
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [5:0] cfg_data
);
    import rc_pkg::*;

    localparam int BW = $clog2(VALUE_WIDTH);

    rc_state_t state_reg, state_next;

    logic [BASE_WIDTH-1:0]  src_base_reg, dst_base_reg;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] prod_reg, prod_next;
    logic [VALUE_WIDTH-1:0] dv_reg, dv_next;
    logic [DIGIT_WIDTH-1:0] digit_reg, digit_next;
    logic                   last_reg, last_next;
    logic [BASE_WIDTH-1:0]  src_sh_reg, src_sh_next;
    logic [2:0]             mul_cnt_reg, mul_cnt_next;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [BASE_WIDTH-1:0]  rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] dig_cnt_reg, dig_cnt_next;
    logic [STACK_AW-1:0]    rd_idx_reg, rd_idx_next;
    logic [BASE_WIDTH-1:0]  rd_data_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [6:0]             m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    logic [BASE_WIDTH-1:0]  stack_mem [STACK_DEPTH];

    logic                   in_acc;
    logic                   out_free;
    logic [BASE_WIDTH-1:0]  base_eff;
    logic [BASE_WIDTH:0]    trial;
    logic                   q_bit;
    logic [BASE_WIDTH-1:0]  rem_step;
    logic [VALUE_WIDTH-1:0] dv_step;
    logic                   div_word_done;
    logic                   div_more;
    logic                   stack_we;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Clamp destination base to 2..36
    always_comb
    begin
        if (dst_base_reg < BASE_MIN)
            base_eff = BASE_MIN;
        else if (dst_base_reg > BASE_MAX)
            base_eff = BASE_MAX;
        else
            base_eff = dst_base_reg;
    end

    // One restoring division step
    always_comb
    begin
        trial = {rem_reg, dv_reg[VALUE_WIDTH-1]};
        q_bit = (trial >= {1'b0, base_eff});
        if (q_bit)
            rem_step = BASE_WIDTH'(trial - {1'b0, base_eff});
        else
            rem_step = trial[BASE_WIDTH-1:0];
        dv_step = {dv_reg[VALUE_WIDTH-2:0], q_bit};
    end

    assign div_word_done = (bit_cnt_reg == '0);
    assign div_more      = (dv_step != '0) &&
                           ((dig_cnt_reg + COUNT_WIDTH'(1)) < COUNT_WIDTH'(STACK_DEPTH));
    assign stack_we      = (state_reg == ST_DIV) && div_word_done;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_MUL;
            ST_MUL:  if (mul_cnt_reg == '0) state_next = ST_ADD;
            ST_ADD:  state_next = last_reg ? ST_DIV : ST_IDLE;
            ST_DIV:  if (div_word_done && !div_more) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_EMIT;
            ST_EMIT:
                if (out_free)
                    state_next = (rd_idx_reg == '0) ? ST_IDLE : ST_LOAD;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb
    begin
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        dv_next      = dv_reg;
        digit_next   = digit_reg;
        last_next    = last_reg;
        src_sh_next  = src_sh_reg;
        mul_cnt_next = mul_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        dig_cnt_next = dig_cnt_reg;
        rd_idx_next  = rd_idx_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                prod_next    = '0;
                src_sh_next  = src_base_reg;
                mul_cnt_next = 3'(BASE_WIDTH - 1);
                digit_next   = char_to_digit(s_tdata);
                last_next    = s_tlast;
            end
            ST_MUL:
            begin
                // MSB-first shift-add: prod = prod*2 + bit*acc
                prod_next    = {prod_reg[VALUE_WIDTH-2:0], 1'b0} +
                               (src_sh_reg[BASE_WIDTH-1] ? acc_reg : '0);
                src_sh_next  = {src_sh_reg[BASE_WIDTH-2:0], 1'b0};
                mul_cnt_next = mul_cnt_reg - 3'd1;
            end
            ST_ADD:
            begin
                acc_next     = prod_reg + VALUE_WIDTH'($signed(digit_reg));
                dv_next      = prod_reg + VALUE_WIDTH'($signed(digit_reg));
                rem_next     = '0;
                bit_cnt_next = BW'(VALUE_WIDTH - 1);
                dig_cnt_next = '0;
                if (last_reg)
                    acc_next = '0;
            end
            ST_DIV:
            begin
                dv_next      = dv_step;
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg - BW'(1);
                if (div_word_done)
                begin
                    rem_next     = '0;
                    bit_cnt_next = BW'(VALUE_WIDTH - 1);
                    dig_cnt_next = dig_cnt_reg + COUNT_WIDTH'(1);
                    rd_idx_next  = dig_cnt_reg[STACK_AW-1:0];
                end
            end
            ST_LOAD:
            begin
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_to_ascii(rd_data_reg);
                    m_last_next  = (rd_idx_reg == '0);
                    rd_idx_next  = rd_idx_reg - STACK_AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            src_base_reg <= BASE_RESET;
            dst_base_reg <= BASE_RESET;
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
            mul_cnt_reg  <= '0;
            bit_cnt_reg  <= '0;
            dig_cnt_reg  <= '0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            mul_cnt_reg <= mul_cnt_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            rd_idx_reg  <= rd_idx_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SRC_BASE: src_base_reg <= cfg_data;
                    REG_DST_BASE: dst_base_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        dv_reg     <= dv_next;
        digit_reg  <= digit_next;
        last_reg   <= last_next;
        src_sh_reg <= src_sh_next;
        rem_reg    <= rem_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    // Digit stack: written at the end of each division, read back in reverse
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[dig_cnt_reg[STACK_AW-1:0]] <= rem_step;
        if (state_reg == ST_LOAD)
            rd_data_reg <= stack_mem[rd_idx_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
